>>> hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation and status codes, and the pipeline types shared by the
// complex arithmetic unit modules.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int FRACTION_BITS = 16;
	localparam int OUT_W = 48;

	localparam int PROD_W = 2 * OPERAND_WIDTH;
	localparam int SUM_W = PROD_W + 1;
	localparam int MAG_W = PROD_W;
	localparam int DEN_W = PROD_W;
	localparam int NB = MAG_W + FRACTION_BITS;
	localparam int EXT_W = ((NB > OUT_W) ? NB : OUT_W) + 1;

	localparam logic [EXT_W-1:0] NEG_LIM = EXT_W'(1) << (OUT_W - 1);
	localparam logic [EXT_W-1:0] POS_LIM = NEG_LIM - EXT_W'(1);

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	localparam int FRONT_STAGES = 4;
	localparam int LATENCY = FRONT_STAGES + NB + 1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic valid;
		logic dz;
		logic neg_re;
		logic neg_im;
	} side_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NB-1:0] nq;
	} div_lane_t;

endpackage

>>> hw/rtl/complex_arith_unit_core.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit core
// Adds, subtracts, multiplies or divides two complex integer operands and
// returns a saturated Q31.16 complex result with a status code.
//
// Channel   Direction  Handshake            Payload
// request   in         start, busy          req_type, a_real, a_imag, b_real, b_imag
// result    out        done (one cycle)     out_real, out_imag, status
//
// One item can be accepted in every cycle; busy stays low.
// Each item passes through the front end, the divider and the output stage;
// the divider resolves one quotient bit per stage for every operation.
// Reset clears the valid bits of all stages; no item is in flight after it.
// Items leave in order, one done cycle each, and the receiver cannot stall.
// ----------------------------------------------------------------------------
module complex_arith_unit_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] req_type,
	input  logic signed [cau_pkg::OPERAND_WIDTH-1:0] a_real,
	input  logic signed [cau_pkg::OPERAND_WIDTH-1:0] a_imag,
	input  logic signed [cau_pkg::OPERAND_WIDTH-1:0] b_real,
	input  logic signed [cau_pkg::OPERAND_WIDTH-1:0] b_imag,
	output logic done,
	output logic signed [cau_pkg::OUT_W-1:0] out_real,
	output logic signed [cau_pkg::OUT_W-1:0] out_imag,
	output logic [1:0] status
);

	cau_pkg::side_t side_f, side_d;
	logic [cau_pkg::DEN_W-1:0] den_f;
	logic [cau_pkg::MAG_W-1:0] mag_re_f, mag_im_f;
	logic [cau_pkg::NB-1:0] q_re_d, q_im_d;

	assign busy = 1'b0;

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.a_real   (a_real),
		.a_imag   (a_imag),
		.b_real   (b_real),
		.b_imag   (b_imag),
		.side_o   (side_f),
		.den_o    (den_f),
		.mag_re_o (mag_re_f),
		.mag_im_o (mag_im_f)
	);

	cau_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_i   (side_f),
		.den_i    (den_f),
		.mag_re_i (mag_re_f),
		.mag_im_i (mag_im_f),
		.side_o   (side_d),
		.q_re_o   (q_re_d),
		.q_im_o   (q_im_d)
	);

	cau_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_i   (side_d),
		.q_re_i   (q_re_d),
		.q_im_i   (q_im_d),
		.done     (done),
		.out_real (out_real),
		.out_imag (out_imag),
		.status   (status)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, cau_pkg::LATENCY))
		else $error("Result strobe without a matching accepted item.");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cau_pkg::ST_DIV0) |-> (out_real == '0 && out_imag == '0))
		else $error("Divide by zero result is not zero.");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cau_pkg::ST_SAT) |->
		(out_real == cau_pkg::OUT_MAX || out_real == cau_pkg::OUT_MIN ||
		 out_imag == cau_pkg::OUT_MAX || out_imag == cau_pkg::OUT_MIN))
		else $error("Saturated status without a part at a bound.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == cau_pkg::ST_OK || status == cau_pkg::ST_SAT ||
		status == cau_pkg::ST_DIV0))
		else $error("Undefined status code.");

endmodule

>>> hw/rtl/cau_front.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Registers the operands, forms the partial products, combines them per
// operation and splits each part into sign and magnitude with a divisor.
// ----------------------------------------------------------------------------
module cau_front (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] req_type,
	input  logic signed [cau_pkg::OPERAND_WIDTH-1:0] a_real,
	input  logic signed [cau_pkg::OPERAND_WIDTH-1:0] a_imag,
	input  logic signed [cau_pkg::OPERAND_WIDTH-1:0] b_real,
	input  logic signed [cau_pkg::OPERAND_WIDTH-1:0] b_imag,
	output cau_pkg::side_t side_o,
	output logic [cau_pkg::DEN_W-1:0] den_o,
	output logic [cau_pkg::MAG_W-1:0] mag_re_o,
	output logic [cau_pkg::MAG_W-1:0] mag_im_o
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	cau_pkg::op_t op_s1, op_s2;
	logic signed [cau_pkg::OPERAND_WIDTH-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [cau_pkg::OPERAND_WIDTH-1:0] ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [cau_pkg::PROD_W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [cau_pkg::PROD_W-1:0] sq_r_s2, sq_i_s2;
	logic signed [cau_pkg::SUM_W-1:0] v_re_s3, v_im_s3;
	logic [cau_pkg::DEN_W-1:0] den_s3, den_s4;
	logic neg_re_s4, neg_im_s4, dz_s4;
	logic [cau_pkg::MAG_W-1:0] mag_re_s4, mag_im_s4;
	logic signed [cau_pkg::SUM_W-1:0] v_re_d, v_im_d;
	logic [cau_pkg::DEN_W-1:0] den_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= cau_pkg::op_t'(req_type);
		ar_s1 <= a_real;
		ai_s1 <= a_imag;
		br_s1 <= b_real;
		bi_s1 <= b_imag;

		op_s2 <= op_s1;
		ar_s2 <= ar_s1;
		ai_s2 <= ai_s1;
		br_s2 <= br_s1;
		bi_s2 <= bi_s1;
		p_rr_s2 <= ar_s1 * br_s1;
		p_ii_s2 <= ai_s1 * bi_s1;
		p_ri_s2 <= ar_s1 * bi_s1;
		p_ir_s2 <= ai_s1 * br_s1;
		sq_r_s2 <= br_s1 * br_s1;
		sq_i_s2 <= bi_s1 * bi_s1;
	end

	always_comb begin
		den_d = cau_pkg::DEN_W'(1);
		unique case (op_s2)
			cau_pkg::OP_ADD: begin
				v_re_d = cau_pkg::SUM_W'(ar_s2) + cau_pkg::SUM_W'(br_s2);
				v_im_d = cau_pkg::SUM_W'(ai_s2) + cau_pkg::SUM_W'(bi_s2);
			end
			cau_pkg::OP_SUB: begin
				v_re_d = cau_pkg::SUM_W'(ar_s2) - cau_pkg::SUM_W'(br_s2);
				v_im_d = cau_pkg::SUM_W'(ai_s2) - cau_pkg::SUM_W'(bi_s2);
			end
			cau_pkg::OP_MUL: begin
				v_re_d = cau_pkg::SUM_W'(p_rr_s2) - cau_pkg::SUM_W'(p_ii_s2);
				v_im_d = cau_pkg::SUM_W'(p_ri_s2) + cau_pkg::SUM_W'(p_ir_s2);
			end
			cau_pkg::OP_DIV: begin
				v_re_d = cau_pkg::SUM_W'(p_rr_s2) + cau_pkg::SUM_W'(p_ii_s2);
				v_im_d = cau_pkg::SUM_W'(p_ir_s2) - cau_pkg::SUM_W'(p_ri_s2);
				den_d = $unsigned(sq_r_s2) + $unsigned(sq_i_s2);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		v_re_s3 <= v_re_d;
		v_im_s3 <= v_im_d;
		den_s3 <= den_d;

		neg_re_s4 <= v_re_s3[cau_pkg::SUM_W-1];
		neg_im_s4 <= v_im_s3[cau_pkg::SUM_W-1];
		mag_re_s4 <= v_re_s3[cau_pkg::SUM_W-1] ? cau_pkg::MAG_W'(-v_re_s3)
			: cau_pkg::MAG_W'(v_re_s3);
		mag_im_s4 <= v_im_s3[cau_pkg::SUM_W-1] ? cau_pkg::MAG_W'(-v_im_s3)
			: cau_pkg::MAG_W'(v_im_s3);
		den_s4 <= den_s3;
		dz_s4 <= (den_s3 == '0);
	end

	assign side_o = '{valid: valid_s4, dz: dz_s4, neg_re: neg_re_s4, neg_im: neg_im_s4};
	assign den_o = den_s4;
	assign mag_re_o = mag_re_s4;
	assign mag_im_o = mag_im_s4;

endmodule

>>> hw/rtl/cau_div_step.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider step
// One registered restoring division step for the real and imaginary lanes,
// producing one quotient bit per lane.
// ----------------------------------------------------------------------------
module cau_div_step (
	input  logic clk,
	input  logic arst_n,
	input  cau_pkg::side_t side_i,
	input  logic [cau_pkg::DEN_W-1:0] den_i,
	input  cau_pkg::div_lane_t re_i,
	input  cau_pkg::div_lane_t im_i,
	output cau_pkg::side_t side_o,
	output logic [cau_pkg::DEN_W-1:0] den_o,
	output cau_pkg::div_lane_t re_o,
	output cau_pkg::div_lane_t im_o
);

	cau_pkg::side_t side_s1;
	logic [cau_pkg::DEN_W-1:0] den_s1;
	cau_pkg::div_lane_t re_s1, im_s1;

	function automatic cau_pkg::div_lane_t step(cau_pkg::div_lane_t l,
			logic [cau_pkg::DEN_W-1:0] d);
		logic [cau_pkg::DEN_W:0] trial;
		logic [cau_pkg::DEN_W:0] diff;
		logic ge;
		cau_pkg::div_lane_t r;
		trial = {l.rem, l.nq[cau_pkg::NB-1]};
		diff = trial - {1'b0, d};
		ge = (trial >= {1'b0, d});
		r.rem = ge ? diff[cau_pkg::DEN_W-1:0] : trial[cau_pkg::DEN_W-1:0];
		r.nq = {l.nq[cau_pkg::NB-2:0], ge};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1 <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		den_s1 <= den_i;
		re_s1 <= step(re_i, den_i);
		im_s1 <= step(im_i, den_i);
	end

	assign side_o = side_s1;
	assign den_o = den_s1;
	assign re_o = re_s1;
	assign im_o = im_s1;

endmodule

>>> hw/rtl/cau_divider.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Pipelined restoring divider, one quotient bit per stage, that divides both
// magnitudes, scaled by the fraction bits, by a shared divisor.
// ----------------------------------------------------------------------------
module cau_divider (
	input  logic clk,
	input  logic arst_n,
	input  cau_pkg::side_t side_i,
	input  logic [cau_pkg::DEN_W-1:0] den_i,
	input  logic [cau_pkg::MAG_W-1:0] mag_re_i,
	input  logic [cau_pkg::MAG_W-1:0] mag_im_i,
	output cau_pkg::side_t side_o,
	output logic [cau_pkg::NB-1:0] q_re_o,
	output logic [cau_pkg::NB-1:0] q_im_o
);

	cau_pkg::side_t side_a [cau_pkg::NB+1];
	logic [cau_pkg::DEN_W-1:0] den_a [cau_pkg::NB+1];
	cau_pkg::div_lane_t re_a [cau_pkg::NB+1];
	cau_pkg::div_lane_t im_a [cau_pkg::NB+1];

	assign side_a[0] = side_i;
	assign den_a[0] = den_i;
	assign re_a[0] = '{rem: '0, nq: cau_pkg::NB'(mag_re_i) << cau_pkg::FRACTION_BITS};
	assign im_a[0] = '{rem: '0, nq: cau_pkg::NB'(mag_im_i) << cau_pkg::FRACTION_BITS};

	for (genvar k = 0; k < cau_pkg::NB; k++) begin : g_step
		cau_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.side_i (side_a[k]),
			.den_i  (den_a[k]),
			.re_i   (re_a[k]),
			.im_i   (im_a[k]),
			.side_o (side_a[k+1]),
			.den_o  (den_a[k+1]),
			.re_o   (re_a[k+1]),
			.im_o   (im_a[k+1])
		);
	end

	assign side_o = side_a[cau_pkg::NB];
	assign q_re_o = re_a[cau_pkg::NB].nq;
	assign q_im_o = im_a[cau_pkg::NB].nq;

endmodule

>>> hw/rtl/cau_pack.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit output stage
// Applies the sign, saturates each part to the output range, forms the
// status code and registers the result with its strobe.
// ----------------------------------------------------------------------------
module cau_pack (
	input  logic clk,
	input  logic arst_n,
	input  cau_pkg::side_t side_i,
	input  logic [cau_pkg::NB-1:0] q_re_i,
	input  logic [cau_pkg::NB-1:0] q_im_i,
	output logic done,
	output logic signed [cau_pkg::OUT_W-1:0] out_real,
	output logic signed [cau_pkg::OUT_W-1:0] out_imag,
	output logic [1:0] status
);

	logic done_q;
	logic signed [cau_pkg::OUT_W-1:0] out_real_q, out_imag_q;
	logic [1:0] status_q;
	logic [cau_pkg::OUT_W:0] re_d, im_d;
	logic [1:0] status_d;

	function automatic logic [cau_pkg::OUT_W:0] sat_part(logic neg,
			logic [cau_pkg::NB-1:0] q);
		logic [cau_pkg::EXT_W-1:0] qe;
		logic [cau_pkg::EXT_W-1:0] lim;
		logic [cau_pkg::OUT_W-1:0] m;
		logic sat;
		qe = cau_pkg::EXT_W'(q);
		lim = neg ? cau_pkg::NEG_LIM : cau_pkg::POS_LIM;
		sat = (qe > lim);
		m = sat ? lim[cau_pkg::OUT_W-1:0] : qe[cau_pkg::OUT_W-1:0];
		return {sat, neg ? -m : m};
	endfunction

	always_comb begin
		re_d = sat_part(side_i.neg_re, q_re_i);
		im_d = sat_part(side_i.neg_im, q_im_i);
		if (side_i.dz) begin
			status_d = cau_pkg::ST_DIV0;
		end else if (re_d[cau_pkg::OUT_W] || im_d[cau_pkg::OUT_W]) begin
			status_d = cau_pkg::ST_SAT;
		end else begin
			status_d = cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		out_real_q <= side_i.dz ? '0 : re_d[cau_pkg::OUT_W-1:0];
		out_imag_q <= side_i.dz ? '0 : im_d[cau_pkg::OUT_W-1:0];
		status_q <= status_d;
	end

	assign done = done_q;
	assign out_real = out_real_q;
	assign out_imag = out_imag_q;
	assign status = status_q;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives add, subtract, multiply and divide items with random gaps, predicts
// each saturated Q31.16 result and its status, and checks every done cycle
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		cau_pkg::op_t op;
		logic signed [15:0] ar;
		logic signed [15:0] ai;
		logic signed [15:0] br;
		logic signed [15:0] bi;
	} cplx_req_t;

	typedef struct {
		logic signed [47:0] re;
		logic signed [47:0] im;
		logic [1:0] st;
	} cplx_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = 2'd0;
	logic signed [15:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic done;
	logic signed [47:0] out_real, out_imag;
	logic [1:0] status;

	cplx_req_t pending[$];
	cplx_res_t predicted[$];
	int errors = 0;
	int gap = 0;
	bit feed_done = 0;
	longint cycles = 0;

	complex_arith_unit_core u_top (.*);

	always #10 clk = ~clk;

	// Saturates a sign and magnitude value with 16 fraction bits to 48 bits.
	function automatic logic signed [47:0] pack_q(bit neg, logic [127:0] mag, ref bit sat);
		logic [127:0] lim;
		lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
		if (mag > lim) begin
			sat = 1;
			mag = lim;
		end
		return neg ? -$signed(mag[47:0]) : $signed(mag[47:0]);
	endfunction

	function automatic logic signed [47:0] int_q(longint v, ref bit sat);
		logic [127:0] m;
		m = (v < 0) ? -v : v;
		return pack_q(v < 0, m << 16, sat);
	endfunction

	function automatic logic signed [47:0] quot_q(longint num, longint den, ref bit sat);
		logic [127:0] m;
		m = (num < 0) ? -num : num;
		m = (m << 16) / den;
		return pack_q(num < 0, m, sat);
	endfunction

	function automatic cplx_res_t complex_result(cplx_req_t q);
		cplx_res_t r;
		bit sat;
		longint ar, ai, br, bi, den;
		sat = 0;
		ar = q.ar;
		ai = q.ai;
		br = q.br;
		bi = q.bi;
		r.re = '0;
		r.im = '0;
		r.st = cau_pkg::ST_OK;
		case (q.op)
			cau_pkg::OP_ADD: begin
				r.re = int_q(ar + br, sat);
				r.im = int_q(ai + bi, sat);
			end
			cau_pkg::OP_SUB: begin
				r.re = int_q(ar - br, sat);
				r.im = int_q(ai - bi, sat);
			end
			cau_pkg::OP_MUL: begin
				r.re = int_q(ar * br - ai * bi, sat);
				r.im = int_q(ar * bi + ai * br, sat);
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.st = cau_pkg::ST_DIV0;
				end else begin
					r.re = quot_q(ar * br + ai * bi, den, sat);
					r.im = quot_q(ai * br - ar * bi, den, sat);
				end
			end
		endcase
		if (r.st == cau_pkg::ST_OK && sat)
			r.st = cau_pkg::ST_SAT;
		return r;
	endfunction

	function automatic logic signed [15:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 6)) - 3);
			3: return 16'(int'($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_req(cau_pkg::op_t op, int ar, int ai, int br, int bi);
		cplx_req_t q;
		q.op = op;
		q.ar = 16'(ar);
		q.ai = 16'(ai);
		q.br = 16'(br);
		q.bi = 16'(bi);
		pending.push_back(q);
	endtask

	initial begin
		cplx_req_t q;
		for (int o = 0; o < 4; o++) begin
			add_req(cau_pkg::op_t'(o), 32767, 32767, 32767, 32767);
			add_req(cau_pkg::op_t'(o), -32768, -32768, -32768, -32768);
			add_req(cau_pkg::op_t'(o), 32767, -32768, -32768, 32767);
			add_req(cau_pkg::op_t'(o), 0, 0, 0, 0);
		end
		add_req(cau_pkg::OP_DIV, 7, -5, 0, 0);
		add_req(cau_pkg::OP_DIV, -7, 3, 2, 0);
		add_req(cau_pkg::OP_DIV, 1, 1, 3, -3);
		add_req(cau_pkg::OP_DIV, 32767, -32768, 1, 0);
		add_req(cau_pkg::OP_DIV, -32768, -32768, 0, -1);
		add_req(cau_pkg::OP_MUL, -32768, 32767, -32768, -32768);
		for (int i = 0; i < 1000; i++) begin
			q.op = cau_pkg::op_t'($urandom_range(0, 3));
			q.ar = rand_part();
			q.ai = rand_part();
			q.br = rand_part();
			q.bi = rand_part();
			pending.push_back(q);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0 && predicted.size() == 0);
		repeat (cau_pkg::LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predicted.push_back(complex_result(pending.pop_front()));
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
			end
			if ((!start || !busy) && pending.size() > 0 && !(start && !busy && gap > 0)
					&& gap == 0) begin
				start <= 1'b1;
				req_type <= pending[0].op;
				a_real <= pending[0].ar;
				a_imag <= pending[0].ai;
				b_real <= pending[0].br;
				b_imag <= pending[0].bi;
			end else if (!start || !busy) begin
				start <= 1'b0;
				if (gap > 0)
					gap = gap - 1;
			end
		end
	end

	always @(posedge clk) begin
		cplx_res_t e;
		if (arst_n && done) begin
			if (predicted.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = predicted.pop_front();
				if (out_real !== e.re) begin
					$error("out_real expected %0d actual %0d", e.re, out_real);
					errors++;
				end
				if (out_imag !== e.im) begin
					$error("out_imag expected %0d actual %0d", e.im, out_imag);
					errors++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
			end
		end
	end

endmodule

>>> sim.f
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div_step.sv
hw/rtl/cau_divider.sv
hw/rtl/cau_pack.sv
hw/rtl/complex_arith_unit_core.sv
verif/tb.sv
